FILE: sv/lidar_scan_sample_deframer_unit_macros.svh
// Assertion helpers shared by the deframer RTL.
`ifndef LIDAR_SCAN_SAMPLE_DEFRAMER_UNIT_MACROS_SVH
`define LIDAR_SCAN_SAMPLE_DEFRAMER_UNIT_MACROS_SVH

// Plain property, sampled on clk_i, off during reset.
`define LSSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define LSSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/lssd_pkg.sv
`default_nettype none

package lssd_pkg;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned PointsW   = $clog2(MaxPoints + 1);
  localparam int unsigned CmpW      = (PointsW > 8) ? PointsW : 8;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned TdataInW  = 16;
  localparam int unsigned TdataOutW = 72;

  localparam logic [7:0] MinPointsReset = 8'd15;
  localparam logic [1:0] SlotNone       = 2'd3;
  localparam logic [7:0] HdrSync0       = 8'hA5;
  localparam logic [7:0] HdrSync1       = 8'h5A;
  localparam logic [2:0] HdrLastPos     = 3'd6;
  localparam logic [2:0] NodeLastPos    = 3'd4;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_BAD_HEADER = 2'd1,
    KIND_SYNC_LOST  = 2'd2,
    KIND_OVERFLOW   = 2'd3
  } kind_e;

  // One classified result waiting for the back end.
  typedef struct packed {
    kind_e            kind;
    logic [31:0]      node;
    logic [7:0]       last_byte;
    logic             scan_start;
    logic [1:0]       slot;
    logic [IdxW-1:0]  point_index;
    logic [1:0]       completed_slot;
    logic [15:0]      completed_count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: sv/lssd_front.sv
`default_nettype none
`include "lidar_scan_sample_deframer_unit_macros.svh"

module lssd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              accept_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [1:0]        reader_slot_i,
  output      logic              push_o,
  output      lssd_pkg::cmd_t    cmd_o
);
  import lssd_pkg::*;

  logic [7:0]         min_pts_q;
  logic               mode_q, mode_d;
  logic [2:0]         pos_q, pos_d;
  logic [31:0]        held_q, held_d, held_base;
  logic [PointsW-1:0] points_q, points_d;
  logic [1:0]         cur_q, cur_d;
  logic [15:0]        count_q, count_d;
  logic               start;
  logic [1:0]         nxt_slot, alt_slot;

  assign held_base = (pos_q == 3'd0) ? 32'd0 : held_q;
  assign start     = held_q[0] & ~held_q[1];

  always_comb begin
    case (cur_q)
      2'd0: begin
        nxt_slot = 2'd1;
        alt_slot = 2'd2;
      end
      2'd1: begin
        nxt_slot = 2'd2;
        alt_slot = 2'd0;
      end
      default: begin
        nxt_slot = 2'd0;
        alt_slot = 2'd1;
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    held_d   = held_q;
    points_d = points_q;
    cur_d    = cur_q;
    count_d  = count_q;
    push_o   = 1'b0;
    cmd_o                 = '0;
    cmd_o.kind            = KIND_SAMPLE;
    cmd_o.node            = held_q;
    cmd_o.last_byte       = rx_byte_i;
    cmd_o.completed_slot  = SlotNone;
    cmd_o.completed_count = count_q;

    if (accept_i) begin
      held_d = held_base;
      if (!pos_q[2]) begin
        case (pos_q[1:0])
          2'd0:    held_d[7:0]   = rx_byte_i;
          2'd1:    held_d[15:8]  = rx_byte_i;
          2'd2:    held_d[23:16] = rx_byte_i;
          default: held_d[31:24] = rx_byte_i;
        endcase
      end

      if (!mode_q) begin
        if (pos_q < HdrLastPos) begin
          pos_d = pos_q + 3'd1;
        end else begin
          pos_d = 3'd0;
          if (held_q[7:0] != HdrSync0 || held_q[15:8] != HdrSync1) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_BAD_HEADER;
          end else begin
            mode_d   = 1'b1;
            points_d = '0;
          end
        end
      end else if (pos_q < NodeLastPos) begin
        pos_d = pos_q + 3'd1;
      end else begin
        pos_d = 3'd0;
        if (start) begin
          if (cur_q != SlotNone && points_q != '0 &&
              CmpW'(points_q) < CmpW'(min_pts_q)) begin
            mode_d     = 1'b0;
            points_d   = '0;
            push_o     = 1'b1;
            cmd_o.kind = KIND_SYNC_LOST;
          end else begin
            if (cur_q != SlotNone) begin
              count_d              = count_q + 16'd1;
              cmd_o.completed_slot = cur_q;
              cur_d                = (nxt_slot == reader_slot_i) ? alt_slot : nxt_slot;
            end else begin
              cur_d = 2'd0;
            end
            points_d              = PointsW'(1);
            push_o                = 1'b1;
            cmd_o.scan_start      = 1'b1;
            cmd_o.slot            = cur_d;
            cmd_o.completed_count = count_d;
          end
        end else if (cur_q != SlotNone) begin
          push_o = 1'b1;
          if (points_q >= PointsW'(MaxPoints)) begin
            cmd_o.kind = KIND_OVERFLOW;
          end else begin
            cmd_o.slot        = cur_q;
            cmd_o.point_index = IdxW'(points_q);
            points_d          = points_q + PointsW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pts_q <= MinPointsReset;
      mode_q    <= 1'b0;
      pos_q     <= 3'd0;
      points_q  <= '0;
      cur_q     <= SlotNone;
      count_q   <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        min_pts_q <= cfg_wdata_i;
      end
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      points_q <= points_d;
      cur_q    <= cur_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  `LSSD_ASSERT(a_points_cap, points_q <= PointsW'(MaxPoints), "point count past capacity")
  `LSSD_ASSERT_IMPL(a_node_pos, mode_q, pos_q <= NodeLastPos, "node byte position out of range")
  `LSSD_ASSERT_IMPL(a_hdr_pos, !mode_q, pos_q <= HdrLastPos, "header byte position out of range")
  `LSSD_ASSERT_IMPL(a_sample_slot, push_o && cmd_o.kind == KIND_SAMPLE,
                    cmd_o.slot != SlotNone, "sample emitted without an open slot")

endmodule

`default_nettype wire

FILE: sv/lssd_queue.sv
`default_nettype none
`include "lidar_scan_sample_deframer_unit_macros.svh"

// Two-entry queue between classifier and output stage.
module lssd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire lssd_pkg::cmd_t      cmd_i,
  input  wire logic                pop_i,
  output      lssd_pkg::cmd_t      cmd_o,
  output      lssd_pkg::q_status_t status_o
);
  import lssd_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign cmd_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `LSSD_ASSERT(a_cnt_range, cnt_q <= 2'd2, "queue count out of range")
  `LSSD_ASSERT_IMPL(a_no_overrun, push_i, !status_o.full, "push into full queue")
  `LSSD_ASSERT_IMPL(a_no_underrun, pop_i, !status_o.empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: sv/lssd_back.sv
`default_nettype none

// Output stage: decodes a queued node into sample fields and holds the beat.
module lssd_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lssd_pkg::cmd_t                  cmd_i,
  input  wire lssd_pkg::q_status_t             status_i,
  output      logic                            pop_o,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [lssd_pkg::TdataOutW-1:0]  m_axis_tdata,
  output      logic [1:0]                      m_axis_tuser
);
  import lssd_pkg::*;

  logic                 valid_q;
  logic [TdataOutW-1:0] data_q, data_d;
  logic [1:0]           kind_q;
  logic                 sample;
  logic [5:0]           quality;
  logic [14:0]          angle;
  logic [15:0]          distance;

  assign sample   = (cmd_i.kind == KIND_SAMPLE);
  assign quality  = sample ? cmd_i.node[7:2] : 6'd0;
  assign angle    = sample ? {cmd_i.node[23:16], cmd_i.node[15:9]} : 15'd0;
  assign distance = sample ? {cmd_i.last_byte, cmd_i.node[31:24]} : 16'd0;

  assign data_d = {4'd0, cmd_i.completed_count, cmd_i.completed_slot, cmd_i.point_index,
                   cmd_i.slot, cmd_i.scan_start, distance, angle, quality};

  assign pop_o = !status_i.empty && (!valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      kind_q <= cmd_i.kind;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = kind_q;

endmodule

`default_nettype wire

FILE: sv/lidar_scan_sample_deframer_unit.sv
// Throughput: one serial byte per cycle while the queue is not full.
// The classifier writes any result of a finished header or node into the two-entry queue;
// the output register then loads it from the queue when the output can take it.
// Reset (rst_ni, async low): header hunting, no slot open, count 0, min points 15.
// Output stalls back up through the queue; input ready drops only when the queue is full.
`default_nettype none

module lidar_scan_sample_deframer_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [7:0]                      cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // [7:0] rx_byte, [9:8] reader_slot, [15:10] zero
  input  wire logic [lssd_pkg::TdataInW-1:0]   s_axis_tdata,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [5:0] quality, [20:6] angle_q6, [36:21] distance_q6, [37] scan_start,
  // [39:38] write_slot_out, [49:40] point_index, [51:50] completed_slot,
  // [67:52] completed_count, [71:68] zero
  output      logic [lssd_pkg::TdataOutW-1:0]  m_axis_tdata,
  // [1:0] kind
  output      logic [1:0]                      m_axis_tuser
);
  import lssd_pkg::*;

  logic      accept, push, pop;
  cmd_t      cmd_in, cmd_out;
  q_status_t q_status;

  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lssd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata[7:0]),
    .reader_slot_i (s_axis_tdata[9:8]),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  lssd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .cmd_o    (cmd_out),
    .status_o (q_status)
  );

  lssd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .status_i      (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
